FILE: design/assert_macros.svh
// Assertion macros for the checker file of the project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define LOT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle
`define LOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lot_pkg.sv
// Package for the LRU order tracker: sizes, request codes, register indexes,
// and the control struct that steers the cell row. Depends on nothing.
package lot_pkg;

    localparam int ENTRIES   = 16;
    localparam int ID_BITS   = 8;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CAP_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        REQ_USE     = 2'd0,
        REQ_DISPOSE = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_FLUSH   = 2'd3
    } t_req_type;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY   = 1'b1;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic use_op;     // use transaction this cycle
        logic hit;        // key found among held ids
        logic dispose_op; // dispose transaction this cycle
        logic flush_op;   // drop the front entry this cycle
    } t_cell_ctrl;

endpackage

FILE: design/lot_req_if.sv
// Request channel of the LRU order tracker: valid/ready plus request fields.
// Depends on lot_pkg.
interface lot_req_if import lot_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [ID_BITS-1:0] item_id;
    logic               notify;

    modport source (output valid, req_type, item_id, notify, input ready);
    modport sink   (input valid, req_type, item_id, notify, output ready);
endinterface

FILE: design/lot_rsp_if.sv
// Result channel of the LRU order tracker: valid/ready plus result fields.
// Depends on lot_pkg.
interface lot_rsp_if import lot_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 evicted_valid;
    logic [ID_BITS-1:0]   evicted_id;
    logic                 least_valid;
    logic [ID_BITS-1:0]   least_id;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 last;

    modport source (output valid, evicted_valid, evicted_id, least_valid, least_id,
                    entry_count, last, input ready);
    modport sink   (input valid, evicted_valid, evicted_id, least_valid, least_id,
                    entry_count, last, output ready);
endinterface

FILE: design/lot_cell.sv
// One slot of the recency row: holds an id, compares it to the key and
// shifts toward either neighbor. Depends on lot_pkg.
module lot_cell import lot_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_valid,
    input  logic [ID_BITS-1:0] i_key,
    input  logic [ID_BITS-1:0] i_left_id,
    input  logic [ID_BITS-1:0] i_right_id,
    input  logic               i_pre,
    input  logic               i_suf,
    output logic [ID_BITS-1:0] o_id,
    output logic [ID_BITS-1:0] o_next_id,
    output logic               o_pre,
    output logic               o_suf
);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    logic               match;
    logic               shift_right;
    logic               shift_left;

    // Compare and pass the match flags along the row in both directions
    assign match = i_valid && (r_id == i_key);
    assign o_pre = i_pre | match;
    assign o_suf = i_suf | match;

    // Use: slots at or before the hit (all slots on a miss) take the left id.
    // Dispose: slots at or after the hit take the right id. Flush: all do.
    assign shift_right = i_ctrl.use_op && (!i_ctrl.hit || o_suf);
    assign shift_left  = i_ctrl.flush_op || (i_ctrl.dispose_op && i_ctrl.hit && o_pre);

    always_comb begin
        n_id = r_id;
        if (shift_right) begin
            n_id = i_left_id;
        end else if (shift_left) begin
            n_id = i_right_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id      = r_id;
    assign o_next_id = n_id;

endmodule

FILE: design/lru_order_tracker.sv
// LRU order tracker: one request per cycle for use, dispose and peek while the
// result output is not stalled; results are registered, so a result appears in the cycle after its request.
// Flush with reporting gives one result per held id (up to ENTRIES), paced by
// the row of cells, which drops its front entry a cycle while the output is free.
// Synchronous active-low reset empties the list (count zero), capacity 0,
// notify enable 1; held ids are not cleared and need no clearing pass.
module lru_order_tracker import lot_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lot_req_if.sink              i_req,
    lot_rsp_if.source            o_rsp
);

    typedef enum logic {S_IDLE, S_FLUSH} t_state;

    t_state               r_state;
    logic [CAP_W-1:0]     r_capacity;
    logic                 r_notify_en;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 r_out_valid;
    logic                 r_ev_valid;
    logic [ID_BITS-1:0]   r_ev_id;
    logic                 r_least_valid;
    logic [ID_BITS-1:0]   r_least_id;
    logic [CNT_OUT_W-1:0] r_entry_count;
    logic                 r_last;

    logic [ID_BITS-1:0]   cell_id   [ENTRIES];
    logic [ID_BITS-1:0]   cell_nid  [ENTRIES];
    logic [ID_BITS-1:0]   left_id   [ENTRIES];
    logic [ID_BITS-1:0]   right_id  [ENTRIES];
    logic                 cell_valid[ENTRIES];
    logic                 pre_in    [ENTRIES];
    logic                 pre_out   [ENTRIES];
    logic                 suf_in    [ENTRIES];
    logic                 suf_out   [ENTRIES];

    t_cell_ctrl           ctrl;
    t_req_type            req;
    logic                 out_free;
    logic                 fire;
    logic                 hit;
    logic                 cap_open;
    logic                 full;
    logic                 flush_report;
    logic                 flush_step;
    logic                 emit;
    logic                 ev_valid;
    logic [ID_BITS-1:0]   ev_id;
    logic                 last;
    logic [ID_BITS-1:0]   cur_least;
    logic [ID_BITS-1:0]   n_least;

    // Handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign fire        = i_req.valid && i_req.ready;
    assign req         = t_req_type'(i_req.req_type);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_notify_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPACITY: r_capacity  <= CAP_W'(i_cfg_data);
                CFG_NOTIFY:   r_notify_en <= i_cfg_data[0];
                default:      r_notify_en <= r_notify_en;
            endcase
        end
    end

    // Row of cells with neighbor wiring
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign cell_valid[g] = (r_count > CNT_W'(g));
            if (g == 0) begin : g_head
                assign left_id[g] = i_req.item_id;
                assign pre_in[g]  = 1'b0;
            end else begin : g_body
                assign left_id[g] = cell_id[g-1];
                assign pre_in[g]  = pre_out[g-1];
            end
            if (g == ENTRIES - 1) begin : g_tail
                assign right_id[g] = '0;
                assign suf_in[g]   = 1'b0;
            end else begin : g_inner
                assign right_id[g] = cell_id[g+1];
                assign suf_in[g]   = suf_out[g+1];
            end

            lot_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_valid    (cell_valid[g]),
                .i_key      (i_req.item_id),
                .i_left_id  (left_id[g]),
                .i_right_id (right_id[g]),
                .i_pre      (pre_in[g]),
                .i_suf      (suf_in[g]),
                .o_id       (cell_id[g]),
                .o_next_id  (cell_nid[g]),
                .o_pre      (pre_out[g]),
                .o_suf      (suf_out[g])
            );
        end
    endgenerate

    assign hit = suf_out[0];

    // Pick the tail id before and after the step
    always_comb begin
        cur_least = '0;
        n_least   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_count == CNT_W'(i + 1)) begin
                cur_least = cur_least | cell_id[i];
            end
            if (n_count == CNT_W'(i + 1)) begin
                n_least = n_least | cell_nid[i];
            end
        end
    end

    // Eviction limit: capacity zero or above the row length means the whole row
    assign cap_open     = (r_capacity == '0) || (CMP_W'(r_capacity) > CMP_W'(ENTRIES));
    assign full         = cap_open ? (CMP_W'(r_count) >= CMP_W'(ENTRIES))
                                   : (CMP_W'(r_count) >= CMP_W'(r_capacity));
    assign flush_report = r_notify_en && (r_count != '0);
    assign flush_step   = ((r_state == S_FLUSH) && out_free)
                        || (fire && (req == REQ_FLUSH) && flush_report);
    assign emit         = fire || ((r_state == S_FLUSH) && out_free);

    // Command for the row
    always_comb begin
        ctrl.use_op     = fire && (req == REQ_USE);
        ctrl.hit        = hit;
        ctrl.dispose_op = fire && (req == REQ_DISPOSE);
        ctrl.flush_op   = flush_step;
    end

    // Next count and result fields
    always_comb begin
        n_count  = r_count;
        ev_valid = 1'b0;
        ev_id    = '0;
        last     = 1'b1;
        if (flush_step) begin
            n_count  = r_count - CNT_W'(1);
            ev_valid = 1'b1;
            ev_id    = cell_id[0];
            last     = (r_count == CNT_W'(1));
        end else if (fire) begin
            unique case (req)
                REQ_USE: begin
                    if (!hit) begin
                        if (full && (r_count != '0)) begin
                            ev_valid = r_notify_en;
                            ev_id    = r_notify_en ? cur_least : '0;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                REQ_DISPOSE: begin
                    if (hit) begin
                        n_count  = r_count - CNT_W'(1);
                        ev_valid = i_req.notify && r_notify_en;
                        ev_id    = ev_valid ? i_req.item_id : '0;
                    end
                end
                REQ_PEEK: begin
                    n_count = r_count;
                end
                REQ_FLUSH: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Hold count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (flush_step) begin
                r_state <= last ? S_IDLE : S_FLUSH;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_ev_valid    <= ev_valid;
            r_ev_id       <= ev_id;
            r_least_valid <= (n_count != '0);
            r_least_id    <= n_least;
            r_entry_count <= CNT_OUT_W'(n_count);
            r_last        <= last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.evicted_valid = r_ev_valid;
    assign o_rsp.evicted_id    = r_ev_id;
    assign o_rsp.least_valid   = r_least_valid;
    assign o_rsp.least_id      = r_least_id;
    assign o_rsp.entry_count   = r_entry_count;
    assign o_rsp.last          = r_last;

endmodule

FILE: design/lot_checker.sv
// Port-level checks for the LRU order tracker, bound to its top level.
// Depends on lot_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lot_checker import lot_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic                 i_rsp_evicted_valid,
    input logic [ID_BITS-1:0]   i_rsp_evicted_id,
    input logic                 i_rsp_least_valid,
    input logic [CNT_OUT_W-1:0] i_rsp_entry_count,
    input logic                 i_rsp_last
);

    // Count stays within the row length
    `LOT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, !i_rsp_valid || (i_rsp_entry_count <= ENTRIES), "entry count above row length")

    // Least id is flagged exactly when entries are held
    `LOT_ASSERT_ALWAYS(a_least_flag, i_clk, i_rst_n, !i_rsp_valid || (i_rsp_least_valid == (i_rsp_entry_count != 0)), "least flag disagrees with count")

    // Unreported removals carry a zero id
    `LOT_ASSERT_ALWAYS(a_evict_zero, i_clk, i_rst_n, !i_rsp_valid || i_rsp_evicted_valid || (i_rsp_evicted_id == 0), "evicted id set without report")

    // No new request while a flush sequence is still reporting
    `LOT_ASSERT_ALWAYS(a_flush_busy, i_clk, i_rst_n, !(i_rsp_valid && !i_rsp_last) || !i_req_ready, "request taken mid-flush")

    // Stalled result stays valid and keeps its evicted id and last flag
    `LOT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_evicted_id) && $stable(i_rsp_last), "stalled result changed")

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_evicted_valid (o_rsp.evicted_valid),
    .i_rsp_evicted_id    (o_rsp.evicted_id),
    .i_rsp_least_valid   (o_rsp.least_valid),
    .i_rsp_entry_count   (o_rsp.entry_count),
    .i_rsp_last          (o_rsp.last)
);
